// ----- rtl/mtfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtfp_pkg: shared constants, types and CRC function for the frame parser
// Sync word, frame layout, result record and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mtfp_pkg;

  localparam int FRAME_LEN = 15;
  localparam int POS_W     = 4;

  localparam logic [7:0]  SYNC_FIRST  = 8'hCD;
  localparam logic [7:0]  SYNC_SECOND = 8'hAB;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  // Last byte position covered by the CRC, and the final frame byte.
  localparam logic [POS_W-1:0] POS_CRC_END = POS_W'(FRAME_LEN - 3);
  localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_SYNC2   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);

  typedef struct packed {
    logic [7:0]         slave_id;
    logic signed [15:0] speed_tenths_rpm;
    logic [15:0]        voltage_centivolts;
    logic signed [15:0] current_centiamps;
    logic signed [31:0] odometer_count;
    logic               crc_ok;
    logic [15:0]        bad_crc_count;
  } result_t;

  typedef struct packed {
    logic    hit;   // this byte closes a frame
    result_t data;
  } frame_result_t;

  // CRC-16/XMODEM, one byte, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mtfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// mtfp_in_stage: input byte register
// Holds one received beat until the parse stage takes it.
// ----------------------------------------------------------------------------
module mtfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       adv,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic take;

  assign rx_stall = held_valid && !adv;
  assign take     = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (adv) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ----- rtl/mtfp_parse.sv -----
// ----------------------------------------------------------------------------
// mtfp_parse: sync hunt, frame buffer and CRC check
// Consumes one byte per enable; flags the frame-closing byte with its result.
// ----------------------------------------------------------------------------
module mtfp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            byte_in,
  output mtfp_pkg::frame_result_t res
);

  logic [mtfp_pkg::POS_W-1:0] pos, pos_next;
  logic [15:0]                crc, crc_next;
  logic [15:0]                bad_cnt, bad_cnt_next;
  logic                       store;
  // bytes 2..13; 0 and 1 are the sync word, 14 arrives with the frame end
  logic [7:0]                 frm [mtfp_pkg::FRAME_LEN-1];

  always_comb begin
    pos_next     = pos;
    crc_next     = crc;
    bad_cnt_next = bad_cnt;
    store        = 1'b0;
    res          = '0;
    if (pos == mtfp_pkg::POS_HUNT) begin
      if (byte_in == mtfp_pkg::SYNC_FIRST) begin
        crc_next = mtfp_pkg::crc_step(16'h0000, byte_in);
        pos_next = mtfp_pkg::POS_SYNC2;
      end
    end else if (pos == mtfp_pkg::POS_SYNC2 && byte_in != mtfp_pkg::SYNC_SECOND) begin
      if (byte_in == mtfp_pkg::SYNC_FIRST) begin
        crc_next = mtfp_pkg::crc_step(16'h0000, byte_in);
        pos_next = mtfp_pkg::POS_SYNC2;
      end else begin
        pos_next = mtfp_pkg::POS_HUNT;
      end
    end else begin
      store = (pos != mtfp_pkg::POS_SYNC2) && (pos != mtfp_pkg::POS_LAST);
      if (pos <= mtfp_pkg::POS_CRC_END) begin
        crc_next = mtfp_pkg::crc_step(crc, byte_in);
      end
      if (pos == mtfp_pkg::POS_LAST) begin
        pos_next = mtfp_pkg::POS_HUNT;
        res.hit  = 1'b1;
        if ({byte_in, frm[mtfp_pkg::POS_CRC_LO]} != crc) begin
          bad_cnt_next           = bad_cnt + 16'd1;
          res.data.crc_ok        = 1'b0;
          res.data.bad_crc_count = bad_cnt_next;
        end else begin
          res.data.slave_id           = frm[2];
          res.data.speed_tenths_rpm   = {frm[4], frm[3]};
          res.data.voltage_centivolts = {frm[6], frm[5]};
          res.data.current_centiamps  = {frm[8], frm[7]};
          res.data.odometer_count     = {frm[12], frm[11], frm[10], frm[9]};
          res.data.crc_ok             = 1'b1;
          res.data.bad_crc_count      = bad_cnt;
        end
      end else begin
        pos_next = pos + mtfp_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= mtfp_pkg::POS_HUNT;
      crc     <= 16'h0000;
      bad_cnt <= 16'h0000;
    end else if (en) begin
      pos     <= pos_next;
      crc     <= crc_next;
      bad_cnt <= bad_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && store) begin
      frm[pos] <= byte_in;
    end
  end

endmodule

// ----- rtl/mtfp_out_stage.sv -----
// ----------------------------------------------------------------------------
// mtfp_out_stage: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mtfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mtfp_pkg::result_t load_data,
  input  logic              res_stall,
  output logic              res_valid,
  output mtfp_pkg::result_t res_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= load_data;
    end
  end

endmodule

// ----- rtl/motor_telemetry_frame_parser_core.sv -----
// Path: a frame result passes the input register, then the result register,
//   on its way from the edge that accepts its last byte to the ports.
// Throughput: one byte per cycle; the parse stage stalls only when a frame
//   closes while the result register still holds an untaken beat.
// Reset (rst, synchronous): returns to sync hunt, clears CRC and bad-CRC
//   count, empties both registers; the frame buffer is not cleared.
// ----------------------------------------------------------------------------
// motor_telemetry_frame_parser_core: telemetry frame parser top level
// Hunts for the 0xCD 0xAB start word, collects a 15-byte frame, checks its
// CRC-16/XMODEM and emits one result beat per frame.
// ----------------------------------------------------------------------------
module motor_telemetry_frame_parser_core (
  input  logic               clk,
  input  logic               rst,
  // received byte channel
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic [7:0]         slave_id,
  output logic signed [15:0] speed_tenths_rpm,
  output logic [15:0]        voltage_centivolts,
  output logic signed [15:0] current_centiamps,
  output logic signed [31:0] odometer_count,
  output logic               crc_ok,
  output logic [15:0]        bad_crc_count
);

  logic                    held_valid;
  logic [7:0]              held_byte;
  logic                    adv;
  logic                    en;
  mtfp_pkg::frame_result_t parse_res;
  mtfp_pkg::result_t       res_data;

  // Parse stage may move unless its byte closes a frame and the result
  // register is full and stalled. Non-closing bytes never wait.
  assign adv = !(parse_res.hit && res_valid && res_stall);
  assign en  = held_valid && adv;

  mtfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .adv        (adv),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Sync hunt, buffer and CRC work on the held byte in one pass.
  mtfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .byte_in (held_byte),
    .res     (parse_res)
  );

  // Result register: loads when a frame closes; the result slot is free or
  // being drained in that same cycle by construction of adv.
  mtfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (en && parse_res.hit),
    .load_data (parse_res.data),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign slave_id           = res_data.slave_id;
  assign speed_tenths_rpm   = res_data.speed_tenths_rpm;
  assign voltage_centivolts = res_data.voltage_centivolts;
  assign current_centiamps  = res_data.current_centiamps;
  assign odometer_count     = res_data.odometer_count;
  assign crc_ok             = res_data.crc_ok;
  assign bad_crc_count      = res_data.bad_crc_count;

endmodule

// ----- rtl/mtfp_checker.sv -----
// ----------------------------------------------------------------------------
// mtfp_checker: port-level checks for the frame parser
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module mtfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               rx_valid,
  input logic               rx_stall,
  input logic [7:0]         rx_byte,
  input logic               res_valid,
  input logic               res_stall,
  input logic [7:0]         slave_id,
  input logic signed [15:0] speed_tenths_rpm,
  input logic [15:0]        voltage_centivolts,
  input logic signed [15:0] current_centiamps,
  input logic signed [31:0] odometer_count,
  input logic               crc_ok,
  input logic [15:0]        bad_crc_count
);

  // Stalled byte beat holds.
  a_rx_hold: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
    else $error("byte beat changed while stalled");

  // Stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(bad_crc_count) && $stable(crc_ok)
      && $stable(odometer_count) && $stable(slave_id))
    else $error("result beat changed while stalled");

  // A failed CRC carries zeroed fields.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !crc_ok |-> slave_id == 8'h00 && speed_tenths_rpm == 16'sd0
      && voltage_centivolts == 16'h0000 && current_centiamps == 16'sd0
      && odometer_count == 32'sd0 && bad_crc_count != 16'h0000)
    else $error("bad-CRC beat carries nonzero fields");

  // No result right out of reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // A new result is loaded only in a cycle the byte side was not stalled.
  a_load_nostall: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(rx_stall))
    else $error("result appeared after a stalled cycle");

endmodule

bind motor_telemetry_frame_parser_core mtfp_checker u_mtfp_checker (.*);

// ----- sim/motor_telemetry_frame_parser_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_telemetry_frame_parser_core_tb: self-checking bench for the frame parser
// Streams serial bytes (directed corner frames, then random frames, corrupted
// frames, broken starts and line noise) into the parser, predicts each frame
// result in-bench and compares every result beat field by field, under random
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module motor_telemetry_frame_parser_core_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [7:0]         slave_id;
  logic signed [15:0] speed_tenths_rpm;
  logic [15:0]        voltage_centivolts;
  logic signed [15:0] current_centiamps;
  logic signed [31:0] odometer_count;
  logic               crc_ok;
  logic [15:0]        bad_crc_count;

  motor_telemetry_frame_parser_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .rx_valid           (rx_valid),
    .rx_stall           (rx_stall),
    .rx_byte            (rx_byte),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .slave_id           (slave_id),
    .speed_tenths_rpm   (speed_tenths_rpm),
    .voltage_centivolts (voltage_centivolts),
    .current_centiamps  (current_centiamps),
    .odometer_count     (odometer_count),
    .crc_ok             (crc_ok),
    .bad_crc_count      (bad_crc_count)
  );

  always #5 clk = ~clk;

  // Bytes still to send, and decoded frames still owed by the parser.
  logic [7:0]        serial_stream [$];
  mtfp_pkg::result_t pending_telemetry [$];

  // Parser shadow state.
  logic [mtfp_pkg::POS_W-1:0] frame_pos = '0;
  logic [7:0]                 frame_buf [mtfp_pkg::FRAME_LEN];
  logic [15:0]                frame_crc = '0;
  logic [15:0]                bad_frames = '0;

  int   fail_count  = 0;
  int   bytes_taken = 0;
  logic rx_taken    = 1'b0;   // byte beat completed at the last rising edge
  logic hold_off    = 1'b0;   // long receiver back-pressure window

  // Sender burst shaping.
  int burst_left = 8;
  int gap_left   = 0;

  // Receiver stall pattern.
  int stall_level = 0;
  int stall_phase = 0;

  // CRC-16/XMODEM, one data bit at a time, MSB first.
  function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ mtfp_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Payload byte biased toward the sign and range edges.
  function automatic logic [7:0] field_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Frame bytes 3..12, byte 3 in the low bits.
  function automatic logic [79:0] random_body();
    logic [79:0] body;
    for (int k = 0; k < 10; k++) begin
      body[8*k +: 8] = field_byte();
    end
    return body;
  endfunction

  // Append a full frame with a correct CRC, optionally with one bit flipped
  // after the CRC was taken (anywhere past the start word).
  task automatic queue_frame(input logic [7:0] slave, input logic [79:0] body,
                             input bit corrupt);
    logic [7:0]  f [mtfp_pkg::FRAME_LEN];
    logic [15:0] crc;
    int          k;
    f[0] = mtfp_pkg::SYNC_FIRST;
    f[1] = mtfp_pkg::SYNC_SECOND;
    f[2] = slave;
    for (k = 0; k < 10; k++) begin
      f[3 + k] = body[8*k +: 8];
    end
    crc = '0;
    for (k = 0; k < mtfp_pkg::FRAME_LEN - 2; k++) begin
      crc = xmodem_update(crc, f[k]);
    end
    f[mtfp_pkg::FRAME_LEN - 2] = crc[7:0];
    f[mtfp_pkg::FRAME_LEN - 1] = crc[15:8];
    if (corrupt) begin
      k    = $urandom_range(2, mtfp_pkg::FRAME_LEN - 1);
      f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (k = 0; k < mtfp_pkg::FRAME_LEN; k++) begin
      serial_stream.push_back(f[k]);
    end
  endtask

  // Shadow parser: advance on one accepted byte, queue a result at frame end.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0]       wire_crc;
    mtfp_pkg::result_t r;
    if (frame_pos == mtfp_pkg::POS_HUNT) begin
      // hunting: anything but the first sync byte is dropped
      if (b == mtfp_pkg::SYNC_FIRST) begin
        frame_buf[0] = b;
        frame_crc    = xmodem_update(16'h0000, b);
        frame_pos    = mtfp_pkg::POS_SYNC2;
      end
    end else if (frame_pos == mtfp_pkg::POS_SYNC2 && b != mtfp_pkg::SYNC_SECOND) begin
      // a repeated first sync byte restarts the frame, anything else aborts
      if (b == mtfp_pkg::SYNC_FIRST) begin
        frame_buf[0] = b;
        frame_crc    = xmodem_update(16'h0000, b);
      end else begin
        frame_pos = mtfp_pkg::POS_HUNT;
      end
    end else begin
      frame_buf[frame_pos] = b;
      if (frame_pos <= mtfp_pkg::POS_CRC_END) begin
        frame_crc = xmodem_update(frame_crc, b);
      end
      if (frame_pos == mtfp_pkg::POS_LAST) begin
        frame_pos = mtfp_pkg::POS_HUNT;
        wire_crc  = {frame_buf[mtfp_pkg::FRAME_LEN - 1], frame_buf[mtfp_pkg::FRAME_LEN - 2]};
        r         = '0;
        if (wire_crc != frame_crc) begin
          // bad CRC: data fields read as zero, count bumps and wraps
          bad_frames = bad_frames + 16'd1;
        end else begin
          r.slave_id           = frame_buf[2];
          r.speed_tenths_rpm   = {frame_buf[4], frame_buf[3]};
          r.voltage_centivolts = {frame_buf[6], frame_buf[5]};
          r.current_centiamps  = {frame_buf[8], frame_buf[7]};
          r.odometer_count     = {frame_buf[12], frame_buf[11], frame_buf[10], frame_buf[9]};
          r.crc_ok             = 1'b1;
        end
        r.bad_crc_count = bad_frames;
        pending_telemetry.push_back(r);
      end else begin
        frame_pos = frame_pos + mtfp_pkg::POS_W'(1);
      end
    end
  endtask

  task automatic report_failure(input string msg);
    if (fail_count < 10) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      report_failure($sformatf("%s expected %h, got %h", name, want, got));
    end
  endtask

  // Monitor: check result beats first, then feed the shadow parser. A byte
  // taken at this edge cannot produce a result at this same edge.
  always @(posedge clk) begin
    mtfp_pkg::result_t want;
    rx_taken <= rx_valid && !rx_stall;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (pending_telemetry.size() == 0) begin
          report_failure("result beat with no frame pending");
        end else begin
          want = pending_telemetry.pop_front();
          check_field("slave_id", 32'(want.slave_id), 32'(slave_id));
          check_field("speed_tenths_rpm", 32'(want.speed_tenths_rpm),
                      32'(speed_tenths_rpm));
          check_field("voltage_centivolts", 32'(want.voltage_centivolts),
                      32'(voltage_centivolts));
          check_field("current_centiamps", 32'(want.current_centiamps),
                      32'(current_centiamps));
          check_field("odometer_count", want.odometer_count, odometer_count);
          check_field("crc_ok", 32'(want.crc_ok), 32'(crc_ok));
          check_field("bad_crc_count", 32'(want.bad_crc_count), 32'(bad_crc_count));
        end
      end
      if (rx_valid && !rx_stall) begin
        parse_rx_byte(rx_byte);
        bytes_taken++;
      end
    end
  end

  // Driver: bursts of beats separated by random gaps; a stalled beat holds.
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (rx_valid && !rx_taken) begin
      // beat still waiting on stall, keep it as is
    end else if (gap_left != 0) begin
      rx_valid <= 1'b0;
      gap_left--;
    end else if (serial_stream.size() != 0) begin
      rx_valid <= 1'b1;
      rx_byte  <= serial_stream.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        // a quarter of bursts run straight into the next one
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      rx_valid <= 1'b0;
    end
  end

  // Receiver: stall density changes from phase to phase (none up to 75%),
  // overridden by the hold-off window.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_level = $urandom_range(0, 3);
      stall_phase = 50;
    end
    stall_phase--;
    res_stall <= hold_off || ($urandom_range(0, 3) < stall_level);
  end

  // Long hold-off mid-run: the result register fills and the parser must
  // push back on the byte channel while the sender keeps offering.
  initial begin
    wait (bytes_taken >= 700);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    int n;
    logic [7:0] noise;

    // Directed: noise while hunting, an aborted start, a doubled first sync
    // byte ahead of a good frame of range edges, then a corrupted frame.
    serial_stream.push_back(8'h00);
    serial_stream.push_back(mtfp_pkg::SYNC_FIRST);
    serial_stream.push_back(8'h12);
    serial_stream.push_back(mtfp_pkg::SYNC_FIRST);
    queue_frame(8'h00, {32'h8000_0000, 16'h7FFF, 16'hFFFF, 16'h8000}, 1'b0);
    queue_frame(8'hFF, {32'h7FFF_FFFF, 16'h8000, 16'h0000, 16'h7FFF}, 1'b1);

    // Random: mostly well-formed frames, some corrupted, some broken starts
    // that swallow what follows, and line noise.
    while (serial_stream.size() < 1950) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        queue_frame(field_byte(), random_body(), 1'b0);
      end else if (kind < 82) begin
        queue_frame(field_byte(), random_body(), 1'b1);
      end else if (kind < 90) begin
        serial_stream.push_back(mtfp_pkg::SYNC_FIRST);
        serial_stream.push_back(mtfp_pkg::SYNC_SECOND);
        n = $urandom_range(0, 10);
        repeat (n) serial_stream.push_back(field_byte());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          noise = ($urandom_range(0, 3) == 0) ? mtfp_pkg::SYNC_FIRST
                                              : 8'($urandom_range(0, 255));
          serial_stream.push_back(noise);
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every byte taken, every frame result seen, then the pipe tail.
    while (serial_stream.size() != 0 || rx_valid) @(posedge clk);
    while (pending_telemetry.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
